FILE: hdl/kolt_pkg.sv
// Package with the word layouts, command codes and cell link types of the keyed list table.
`timescale 1ns / 1ps
`default_nettype none

package kolt_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int CMD_W        = 3;
   localparam int KEY_W        = 16;
   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 5;

   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  second_key;
      logic [DATA_W-1:0] record_data;
   } req_word_type;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] found_data;
      logic [COUNT_W-1:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } rec_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic             cmp_en;
      logic             exe_en;
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key1;
      logic [KEY_W-1:0] key2;
      rec_type          new_rec;
      rec_type          first_rec;
      rec_type          a_rec;
      rec_type          b_rec;
      logic             found1;
      logic             found_ab;
   } cell_bcast_type;

   // Link running from the front of the list toward the tail.
   typedef struct packed {
      logic    is_head;
      logic    valid;
      logic    seen;
      rec_type rec;
   } lr_link_type;

   // Link running from the tail toward the front.
   typedef struct packed {
      logic    valid;
      rec_type rec;
      logic    after1;
      logic    after2;
      rec_type first_rec;
      rec_type a_rec;
      rec_type b_rec;
   } rl_link_type;

endpackage

`default_nettype wire

FILE: hdl/kolt_chan_if.sv
// Valid/ready channel interface carrying one word per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface kolt_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/kolt_cell.sv
// One slot of the list: holds a record, matches keys and moves records to its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module kolt_cell
   import kolt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cell_bcast_type bc,
   input  wire lr_link_type    from_left,
   output      lr_link_type    to_right,
   input  wire rl_link_type    from_right,
   output      rl_link_type    to_left
);

   rec_type rec_ff, rec_in;
   logic    valid_ff, valid_in;
   logic    m1_ff, m1_in;
   logic    m2_ff, m2_in;
   logic    seen_incl;
   logic    first_hit;
   logic    a_last;
   logic    b_last;

   assign seen_incl = from_left.seen | m1_ff;
   assign first_hit = m1_ff & ~from_left.seen;
   assign a_last    = m1_ff & ~from_right.after1;
   assign b_last    = m2_ff & ~from_right.after2;

   always_comb begin
      to_right.is_head = 1'b0;
      to_right.valid   = valid_ff;
      to_right.seen    = seen_incl;
      to_right.rec     = rec_ff;

      to_left.valid     = valid_ff;
      to_left.rec       = rec_ff;
      to_left.after1    = from_right.after1 | m1_ff;
      to_left.after2    = from_right.after2 | m2_ff;
      to_left.first_rec = first_hit ? rec_ff : from_right.first_rec;
      to_left.a_rec     = a_last ? rec_ff : from_right.a_rec;
      to_left.b_rec     = b_last ? rec_ff : from_right.b_rec;
   end

   always_comb begin
      m1_in = m1_ff;
      m2_in = m2_ff;
      if (bc.cmp_en) begin
         m1_in = valid_ff && (rec_ff.key == bc.key1);
         m2_in = valid_ff && (rec_ff.key == bc.key2);
      end
   end

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (bc.exe_en) begin
         case (bc.cmd)
            CMD_APPEND: begin
               // The tail is the first empty slot behind a full one or behind the head.
               if (!valid_ff && from_left.valid) begin
                  rec_in   = bc.new_rec;
                  valid_in = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (bc.found1 && seen_incl) begin
                  rec_in   = from_right.rec;
                  valid_in = from_right.valid;
               end
            end
            CMD_SWAP: begin
               if (bc.found_ab) begin
                  if (a_last) begin
                     rec_in = bc.b_rec;
                  end else if (b_last) begin
                     rec_in = bc.a_rec;
                  end
               end
            end
            CMD_FRONT: begin
               // Slots up to and including the first match shift back by one.
               if (bc.found1 && !from_left.seen) begin
                  rec_in = from_left.is_head ? bc.first_rec : from_left.rec;
               end
            end
            CMD_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      m1_ff  <= m1_in;
      m2_ff  <= m2_in;
   end

endmodule

`default_nettype wire

FILE: hdl/keyed_ordered_list_table_unit.sv
// Top level of the keyed ordered list table: controller and the chain of slot cells.
//
//  Channel    Direction  Word            Handshake
//  req_chan   in         req_word_type   valid/ready
//  rsp_chan   out        rsp_word_type   valid/ready
//
// A word passes through a compare cycle, in which every cell registers its key
// matches, and an execute cycle, in which match flags and selected records ripple
// along the chain and every cell loads its new record. The next word is taken in
// the execute cycle, so a new word is taken only as the previous one executes.
// Reset is synchronous and clears the slot valid bits and the count; no clearing pass.
// While a result waits on a stalled output, the execute cycle holds and no word is taken.
`timescale 1ns / 1ps
`default_nettype none

module keyed_ordered_list_table_unit
   import kolt_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kolt_chan_if.sink   req_chan,
   kolt_chan_if.source rsp_chan
);

   localparam int FW = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_EXE  = 2'd2;

   logic [1:0]    state_ff, state_in;
   req_word_type  cmd_ff, cmd_in;
   rsp_word_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW+COUNT_W-1:0] count_wide;

   logic accept;
   logic fire;
   logic ok;
   logic found1;
   logic found_ab;
   logic table_full;

   cell_bcast_type      bc;
   lr_link_type         lr [CAPACITY+1];
   rl_link_type         rl [CAPACITY+1];
   logic [CAPACITY-1:0] cell_valid;

   assign fire   = (state_ff == ST_EXE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == ST_IDLE) || fire;
   assign accept = req_chan.valid && req_chan.ready;

   assign lr[0] = '{is_head: 1'b1, valid: 1'b1, seen: 1'b0, rec: '0};
   assign rl[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      kolt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .bc         (bc),
         .from_left  (lr[i]),
         .to_right   (lr[i+1]),
         .from_right (rl[i+1]),
         .to_left    (rl[i])
      );
      assign cell_valid[i] = lr[i+1].valid;
   end

   assign found1     = rl[0].after1;
   assign found_ab   = rl[0].after1 & rl[0].after2;
   assign table_full = lr[CAPACITY].valid;

   always_comb begin
      bc.cmp_en    = (state_ff == ST_CMP);
      bc.exe_en    = fire;
      bc.cmd       = cmd_ff.cmd;
      bc.key1      = cmd_ff.key;
      bc.key2      = cmd_ff.second_key;
      bc.new_rec   = '{key: cmd_ff.key, data: cmd_ff.record_data};
      bc.first_rec = rl[0].first_rec;
      bc.a_rec     = rl[0].a_rec;
      bc.b_rec     = rl[0].b_rec;
      bc.found1    = found1;
      bc.found_ab  = found_ab;
   end

   always_comb begin
      case (cmd_ff.cmd)
         CMD_APPEND: ok = !table_full;
         CMD_SWAP:   ok = found_ab;
         CMD_CLEAR:  ok = 1'b1;
         default:    ok = (cmd_ff.cmd inside {CMD_REMOVE, CMD_FRONT, CMD_FIND}) && found1;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (fire) begin
         if (cmd_ff.cmd == CMD_APPEND && ok) begin
            fill_in = fill_ff + FW'(1);
         end else if (cmd_ff.cmd == CMD_REMOVE && ok) begin
            fill_in = fill_ff - FW'(1);
         end else if (cmd_ff.cmd == CMD_CLEAR) begin
            fill_in = '0;
         end
      end
   end

   assign count_wide = {{COUNT_W{1'b0}}, fill_in};

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff;
      if (fire) begin
         rsp_in.ok          = ok;
         rsp_in.found_data  = (cmd_ff.cmd == CMD_FIND && found1) ? rl[0].first_rec.data : '0;
         rsp_in.entry_count = count_wide[COUNT_W-1:0];
         rsp_valid_in       = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in       = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      if (accept) begin
         state_in = ST_CMP;
         cmd_in   = req_chan.payload;
      end else if (fire) begin
         state_in = ST_IDLE;
      end else if (state_ff == ST_CMP) begin
         state_in = ST_EXE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // The count must always agree with the number of occupied slots.
   a_fill_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(fill_ff))
      else $error("entry count disagrees with occupied slots");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_to_compare: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CMP)
      else $error("accepted word did not enter the compare cycle");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && $past(cmd_ff.cmd) == $past(cmd_ff.cmd))
      else $error("executed word produced no result");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the keyed ordered list table, driven through its word channels.
`timescale 1ns / 1ps

module tb_top;
   import kolt_pkg::*;

   localparam int               CAPACITY   = DEF_CAPACITY;
   localparam int               STALL_LIMIT = 1000;
   localparam int               DRAIN_CYCLES = 8;
   localparam int               RANDOM_WORDS = 500;
   localparam int               STEADY_WORDS = 100;
   // Command codes that the block does not define.
   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

   logic clock = 1'b0;
   logic reset;

   kolt_chan_if #(.payload_type(req_word_type)) req_if ();
   kolt_chan_if #(.payload_type(rsp_word_type)) rsp_if ();

   keyed_ordered_list_table_unit #(
      .CAPACITY (CAPACITY)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predicted list contents, front of the list at index 0.
   logic [KEY_W-1:0]  list_key [CAPACITY];
   logic [DATA_W-1:0] list_data [CAPACITY];
   int                list_count;
   logic [KEY_W-1:0]  key_pool [8];

   rsp_word_type expected_rsp [$];
   int           fail_count;
   int           quiet_cycles;
   bit           idling_on;

   function automatic int first_slot(input logic [KEY_W-1:0] k);
      for (int i = 0; i < list_count; i++) begin
         if (list_key[i] == k) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic int last_slot(input logic [KEY_W-1:0] k);
      int hit;
      hit = -1;
      for (int i = 0; i < list_count; i++) begin
         if (list_key[i] == k) begin
            hit = i;
         end
      end
      return hit;
   endfunction

   function automatic rsp_word_type apply_command(input req_word_type w);
      rsp_word_type      r;
      int                a;
      int                b;
      logic [KEY_W-1:0]  tk;
      logic [DATA_W-1:0] td;
      r = '0;
      case (w.cmd)
         CMD_APPEND: begin
            if (list_count < CAPACITY) begin
               list_key[list_count]  = w.key;
               list_data[list_count] = w.record_data;
               list_count++;
               r.ok = 1'b1;
            end
         end
         CMD_REMOVE: begin
            a = first_slot(w.key);
            if (a >= 0) begin
               for (int i = a; i < list_count - 1; i++) begin
                  list_key[i]  = list_key[i + 1];
                  list_data[i] = list_data[i + 1];
               end
               list_count--;
               r.ok = 1'b1;
            end
         end
         CMD_SWAP: begin
            a = last_slot(w.key);
            b = last_slot(w.second_key);
            if (a >= 0 && b >= 0) begin
               tk = list_key[a];
               td = list_data[a];
               list_key[a]  = list_key[b];
               list_data[a] = list_data[b];
               list_key[b]  = tk;
               list_data[b] = td;
               r.ok = 1'b1;
            end
         end
         CMD_FRONT: begin
            a = first_slot(w.key);
            if (a >= 0) begin
               tk = list_key[a];
               td = list_data[a];
               for (int i = a; i > 0; i--) begin
                  list_key[i]  = list_key[i - 1];
                  list_data[i] = list_data[i - 1];
               end
               list_key[0]  = tk;
               list_data[0] = td;
               r.ok = 1'b1;
            end
         end
         CMD_FIND: begin
            a = first_slot(w.key);
            if (a >= 0) begin
               r.found_data = list_data[a];
               r.ok = 1'b1;
            end
         end
         CMD_CLEAR: begin
            list_count = 0;
            r.ok = 1'b1;
         end
         default: begin
         end
      endcase
      r.entry_count = list_count[COUNT_W-1:0];
      return r;
   endfunction

   // Sends one word, with an optional idle burst first, and records its expected result.
   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k1,
                        input logic [KEY_W-1:0] k2, input logic [DATA_W-1:0] data);
      req_word_type w;
      int           gap;
      w.cmd         = cmd;
      w.key         = k1;
      w.second_key  = k2;
      w.record_data = data;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.payload <= w;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      expected_rsp.push_back(apply_command(w));
   endtask

   // Keys mostly come from a small pool or from the list itself so that matches are common.
   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4 && list_count > 0) begin
         return list_key[$urandom_range(0, list_count - 1)];
      end else if (sel < 7) begin
         return key_pool[$urandom_range(0, 7)];
      end else if (sel == 7) begin
         return {KEY_W{1'b0}};
      end else if (sel == 8) begin
         return {KEY_W{1'b1}};
      end
      return KEY_W'($urandom);
   endfunction

   task automatic random_word();
      logic [CMD_W-1:0] cmd;
      int               sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         cmd = CMD_APPEND;
      end else if (sel < 45) begin
         cmd = CMD_REMOVE;
      end else if (sel < 58) begin
         cmd = CMD_SWAP;
      end else if (sel < 71) begin
         cmd = CMD_FRONT;
      end else if (sel < 93) begin
         cmd = CMD_FIND;
      end else if (sel < 96) begin
         cmd = CMD_CLEAR;
      end else if (sel < 98) begin
         cmd = CMD_SPARE6;
      end else begin
         cmd = CMD_SPARE7;
      end
      issue(cmd, pick_key(), pick_key(), $urandom);
   endtask

   // Runs of appends that fill the table and then overflow it, between stretches of mixed words.
   task automatic random_run(input int words);
      int sent;
      int extra;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 9) == 0) begin
            extra = $urandom_range(1, 2);
            while (list_count < CAPACITY || extra > 0) begin
               if (list_count == CAPACITY) begin
                  extra--;
               end
               issue(CMD_APPEND, pick_key(), KEY_W'($urandom), $urandom);
               sent++;
            end
         end else begin
            random_word();
            sent++;
         end
      end
   endtask

   task automatic test_empty_table();
      issue(CMD_FIND, 16'h0000, 16'h0000, 32'h0);
      issue(CMD_REMOVE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
      issue(CMD_SWAP, 16'h0000, 16'hFFFF, 32'h0);
      issue(CMD_FRONT, 16'h1234, 16'h0000, 32'h0);
      issue(CMD_SPARE6, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      issue(CMD_SPARE7, 16'h0000, 16'h0000, 32'h0);
      issue(CMD_CLEAR, 16'h0000, 16'h0000, 32'h0);
   endtask

   task automatic test_list_ops();
      issue(CMD_APPEND, 16'h0000, 16'hFFFF, 32'h0000_0000);
      issue(CMD_APPEND, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
      issue(CMD_APPEND, 16'h1234, 16'h0000, 32'hA5A5_5A5A);
      issue(CMD_APPEND, 16'h0000, 16'h0000, 32'h5A5A_A5A5);
      // A duplicated key is found at its first slot but swapped at its last.
      issue(CMD_FIND, 16'h0000, 16'h0000, 32'h0);
      issue(CMD_SWAP, 16'h0000, 16'hFFFF, 32'h0);
      issue(CMD_SWAP, 16'h1234, 16'h1234, 32'h0);
      issue(CMD_SWAP, 16'h1234, 16'h7777, 32'h0);
      issue(CMD_FRONT, 16'h1234, 16'h0000, 32'h0);
      issue(CMD_FRONT, 16'h1234, 16'h0000, 32'h0);
      issue(CMD_FRONT, 16'h7777, 16'h0000, 32'h0);
      issue(CMD_REMOVE, 16'hFFFF, 16'h0000, 32'h0);
      issue(CMD_REMOVE, 16'h7777, 16'h0000, 32'h0);
      issue(CMD_FIND, 16'h0000, 16'h0000, 32'h0);
      issue(CMD_FIND, 16'h5555, 16'h0000, 32'h0);
      issue(CMD_CLEAR, 16'h0000, 16'h0000, 32'h0);
      issue(CMD_FIND, 16'h1234, 16'h0000, 32'h0);
   endtask

   task automatic test_random_idling();
      idling_on = 1'b1;
      random_run(RANDOM_WORDS);
   endtask

   task automatic test_random_full_rate();
      idling_on = 1'b0;
      random_run(STEADY_WORDS);
   endtask

   // Result side: stall bursts while idling is on, otherwise always ready.
   initial begin
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result word %p", $time, rsp_if.payload);
            fail_count++;
         end else begin
            if (rsp_if.payload.ok !== expected_rsp[0].ok) begin
               $display("%0t: ok expected %0b actual %0b", $time,
                        expected_rsp[0].ok, rsp_if.payload.ok);
               fail_count++;
            end
            if (rsp_if.payload.found_data !== expected_rsp[0].found_data) begin
               $display("%0t: found_data expected %h actual %h", $time,
                        expected_rsp[0].found_data, rsp_if.payload.found_data);
               fail_count++;
            end
            if (rsp_if.payload.entry_count !== expected_rsp[0].entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        expected_rsp[0].entry_count, rsp_if.payload.entry_count);
               fail_count++;
            end
            void'(expected_rsp.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      idling_on      = 1'b1;
      fail_count     = 0;
      quiet_cycles   = 0;
      list_count     = 0;
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < 8; i++) begin
         key_pool[i] = KEY_W'($urandom);
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_list_ops();
      test_random_idling();
      test_random_full_rate();

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/kolt_pkg.sv
hdl/kolt_chan_if.sv
hdl/kolt_cell.sv
hdl/keyed_ordered_list_table_unit.sv
tb/tb_top.sv
